// ----- src/rsp_pkg.sv -----
// Package for the key-value protocol stream parser: phase and role codes, sizes.
// No dependencies.
package rsp_pkg;
	localparam int unsigned DEF_MAX_DEPTH = 16;

	typedef enum logic [2:0] {
		PH_BEGIN,
		PH_LINE,
		PH_LEN,
		PH_BULK,
		PH_BULKEND
	} phase_t;

	localparam logic [2:0] ROLE_MARKER  = 3'd0;
	localparam logic [2:0] ROLE_TEXT    = 3'd1;
	localparam logic [2:0] ROLE_LENGTH  = 3'd2;
	localparam logic [2:0] ROLE_PAYLOAD = 3'd3;
	localparam logic [2:0] ROLE_CRLF    = 3'd4;
	localparam logic [2:0] ROLE_IGNORED = 3'd5;

	localparam logic [2:0] TYPE_UNKNOWN = 3'd0;
	localparam logic [2:0] TYPE_STATUS  = 3'd1;
	localparam logic [2:0] TYPE_ERROR   = 3'd2;
	localparam logic [2:0] TYPE_INTEGER = 3'd3;
	localparam logic [2:0] TYPE_BULK    = 3'd4;
	localparam logic [2:0] TYPE_ARRAY   = 3'd5;

	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	typedef struct packed {
		logic       restart;
		logic       clear_item;
		logic       set_neg;
		logic       neg_val;
		logic       acc_load;
		logic       bulk_load;
		logic       bulk_dec;
		logic       push;
		logic       complete;
	} rsp_cmd_t;

	typedef struct packed {
		logic       acc_zero;
		logic       neg;
		logic       digit_ovf;
		logic       bulk_last;
		logic       stack_full;
		logic       pop_empty;
	} rsp_stat_t;
endpackage

// ----- src/rsp_datapath.sv -----
// Datapath: length accumulator, bulk counter and array count stack.
// Depends on rsp_pkg.
module rsp_datapath #(
	parameter int unsigned MAX_DEPTH = rsp_pkg::DEF_MAX_DEPTH,
	localparam int unsigned LW = $clog2(MAX_DEPTH + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic [7:0]          data_byte,
	input  rsp_pkg::rsp_cmd_t   cmd,
	output rsp_pkg::rsp_stat_t  stat,
	output logic [31:0]         length_value,
	output logic [LW-1:0]       open_levels,
	output logic [LW-1:0]       next_open
);
	logic [31:0]   acc_q;
	logic          neg_q;
	logic [31:0]   bulk_q;
	logic [31:0]   lvl_q [MAX_DEPTH];
	logic [LW-1:0] open_q;
	logic [35:0]   nv;
	logic [35:0]   lim;
	logic [MAX_DEPTH-1:0] one_left;
	logic [LW-1:0] pops;
	logic [LW-1:0] new_open;
	logic          stop;

	assign nv = {4'd0, acc_q} * 36'd10 + {28'd0, data_byte - rsp_pkg::CH_ZERO};
	assign lim = neg_q ? 36'h080000000 : 36'h07FFFFFFF;

	always_comb begin
		for (int i = 0; i < MAX_DEPTH; i++) begin
			one_left[i] = (lvl_q[i] <= 32'd1);
		end
		// cascaded pops: count consecutive finished levels from the top
		pops = '0;
		stop = 1'b0;
		for (int i = MAX_DEPTH - 1; i >= 0; i--) begin
			if (LW'(i) < open_q && !stop) begin
				if (one_left[i]) begin
					pops = pops + LW'(1);
				end else begin
					stop = 1'b1;
				end
			end
		end
		new_open = open_q - pops;
	end

	assign stat.acc_zero   = (acc_q == 32'd0);
	assign stat.neg        = neg_q;
	assign stat.digit_ovf  = (nv > lim);
	assign stat.bulk_last  = (bulk_q <= 32'd1);
	assign stat.stack_full = (open_q >= LW'(MAX_DEPTH));
	assign stat.pop_empty  = (new_open == '0);
	assign length_value    = neg_q ? (32'd0 - acc_q) : acc_q;
	assign open_levels     = open_q;
	assign next_open       = new_open;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			neg_q  <= 1'b0;
			bulk_q <= '0;
			open_q <= '0;
		end else if (en) begin
			if (cmd.restart) begin
				acc_q  <= '0;
				neg_q  <= 1'b0;
				bulk_q <= '0;
				open_q <= '0;
			end else begin
				if (cmd.clear_item) begin
					acc_q <= '0;
					neg_q <= 1'b0;
				end
				if (cmd.set_neg) neg_q <= cmd.neg_val;
				if (cmd.acc_load) acc_q <= nv[31:0];
				if (cmd.bulk_load) bulk_q <= acc_q;
				else if (cmd.bulk_dec && bulk_q != 32'd0) bulk_q <= bulk_q - 32'd1;
				if (cmd.push) open_q <= open_q + LW'(1);
				else if (cmd.complete) open_q <= new_open;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < MAX_DEPTH; i++) begin
				if (!cmd.restart && cmd.push && LW'(i) == open_q) begin
					lvl_q[i] <= acc_q;
				end else if (!cmd.restart && cmd.complete && !cmd.push
						&& new_open != '0 && LW'(i) == new_open - LW'(1)) begin
					lvl_q[i] <= lvl_q[i] - 32'd1;
				end
			end
		end
	end
endmodule

// ----- src/rsp_ctrl.sv -----
// Controller state machine: phase, line/number flags, type and done/fail flags.
// Depends on rsp_pkg.
module rsp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                req_type,
	input  logic [7:0]          data_byte,
	input  rsp_pkg::rsp_stat_t  stat,
	output rsp_pkg::rsp_cmd_t   cmd,
	output logic [2:0]          byte_role,
	output logic [2:0]          item_type,
	output logic                length_valid,
	output logic                element_done,
	output logic                message_done,
	output logic                parse_failed
);
	rsp_pkg::phase_t phase_q, phase_d;
	logic       text_q, text_d;
	logic [1:0] nstage_q, nstage_d;
	logic [2:0] type_q, type_d;
	logic       done_q, done_d;
	logic       fail_q, fail_d;
	logic       is_digit, is_blank;

	assign is_digit = data_byte >= rsp_pkg::CH_ZERO && data_byte <= rsp_pkg::CH_NINE;
	assign is_blank = data_byte == rsp_pkg::CH_SPACE || data_byte == rsp_pkg::CH_TAB
		|| data_byte == rsp_pkg::CH_VT || data_byte == rsp_pkg::CH_FF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= rsp_pkg::PH_BEGIN;
			text_q   <= 1'b0;
			nstage_q <= 2'd0;
			type_q   <= rsp_pkg::TYPE_UNKNOWN;
			done_q   <= 1'b0;
			fail_q   <= 1'b0;
		end else if (en) begin
			phase_q  <= phase_d;
			text_q   <= text_d;
			nstage_q <= nstage_d;
			type_q   <= type_d;
			done_q   <= done_d;
			fail_q   <= fail_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		text_d = text_q;
		nstage_d = nstage_q;
		type_d = type_q;
		done_d = done_q;
		fail_d = fail_q;
		cmd = '0;
		byte_role = rsp_pkg::ROLE_IGNORED;
		length_valid = 1'b0;
		element_done = 1'b0;
		message_done = 1'b0;
		if (req_type) begin
			cmd.restart = 1'b1;
			phase_d = rsp_pkg::PH_BEGIN;
			text_d = 1'b0;
			nstage_d = 2'd0;
			type_d = rsp_pkg::TYPE_UNKNOWN;
			done_d = 1'b0;
			fail_d = 1'b0;
		end else if (!done_q && !fail_q) begin
			unique case (phase_q)
				rsp_pkg::PH_BEGIN: begin
					byte_role = rsp_pkg::ROLE_MARKER;
					cmd.clear_item = 1'b1;
					text_d = 1'b0;
					nstage_d = 2'd0;
					phase_d = rsp_pkg::PH_LINE;
					unique case (data_byte)
						rsp_pkg::CH_COLON:  type_d = rsp_pkg::TYPE_INTEGER;
						rsp_pkg::CH_PLUS:   type_d = rsp_pkg::TYPE_STATUS;
						rsp_pkg::CH_MINUS:  type_d = rsp_pkg::TYPE_ERROR;
						rsp_pkg::CH_DOLLAR: begin
							type_d = rsp_pkg::TYPE_BULK;
							phase_d = rsp_pkg::PH_LEN;
						end
						rsp_pkg::CH_STAR: begin
							type_d = rsp_pkg::TYPE_ARRAY;
							phase_d = rsp_pkg::PH_LEN;
						end
						default: begin
							type_d = rsp_pkg::TYPE_UNKNOWN;
							phase_d = rsp_pkg::PH_BEGIN;
							fail_d = 1'b1;
						end
					endcase
				end
				rsp_pkg::PH_LINE: begin
					if (data_byte == rsp_pkg::CH_CR) begin
						byte_role = rsp_pkg::ROLE_CRLF;
					end else if (data_byte == rsp_pkg::CH_LF) begin
						byte_role = rsp_pkg::ROLE_CRLF;
						if (!text_q) begin
							fail_d = 1'b1;
						end else begin
							element_done = 1'b1;
							cmd.complete = 1'b1;
						end
					end else begin
						byte_role = rsp_pkg::ROLE_TEXT;
						text_d = 1'b1;
					end
				end
				rsp_pkg::PH_LEN: begin
					if (data_byte == rsp_pkg::CH_CR) begin
						byte_role = rsp_pkg::ROLE_CRLF;
					end else if (data_byte == rsp_pkg::CH_LF) begin
						byte_role = rsp_pkg::ROLE_CRLF;
						if (nstage_q != 2'd2) begin
							fail_d = 1'b1;
						end else begin
							length_valid = 1'b1;
							if (stat.neg || stat.acc_zero) begin
								if (type_q == rsp_pkg::TYPE_BULK && stat.acc_zero) begin
									phase_d = rsp_pkg::PH_BULKEND;
								end else begin
									element_done = 1'b1;
									cmd.complete = 1'b1;
								end
							end else if (type_q == rsp_pkg::TYPE_BULK) begin
								cmd.bulk_load = 1'b1;
								phase_d = rsp_pkg::PH_BULK;
							end else if (stat.stack_full) begin
								fail_d = 1'b1;
							end else begin
								cmd.push = 1'b1;
								cmd.clear_item = 1'b1;
								phase_d = rsp_pkg::PH_BEGIN;
								text_d = 1'b0;
								nstage_d = 2'd0;
							end
						end
					end else begin
						byte_role = rsp_pkg::ROLE_LENGTH;
						if (nstage_q == 2'd0 && is_blank) begin
							nstage_d = 2'd0;
						end else if (nstage_q == 2'd0 && (data_byte == rsp_pkg::CH_PLUS
								|| data_byte == rsp_pkg::CH_MINUS)) begin
							cmd.set_neg = 1'b1;
							cmd.neg_val = (data_byte == rsp_pkg::CH_MINUS);
							nstage_d = 2'd1;
						end else if (is_digit) begin
							nstage_d = 2'd2;
							if (stat.digit_ovf) fail_d = 1'b1;
							else cmd.acc_load = 1'b1;
						end else begin
							fail_d = 1'b1;
						end
					end
				end
				rsp_pkg::PH_BULK: begin
					byte_role = rsp_pkg::ROLE_PAYLOAD;
					cmd.bulk_dec = 1'b1;
					if (stat.bulk_last) phase_d = rsp_pkg::PH_BULKEND;
				end
				rsp_pkg::PH_BULKEND: begin
					byte_role = rsp_pkg::ROLE_CRLF;
					if (data_byte == rsp_pkg::CH_LF) begin
						element_done = 1'b1;
						cmd.complete = 1'b1;
					end else if (data_byte != rsp_pkg::CH_CR) begin
						fail_d = 1'b1;
					end
				end
				default: fail_d = 1'b1;
			endcase
			if (cmd.complete) begin
				if (stat.pop_empty) begin
					done_d = 1'b1;
					message_done = 1'b1;
				end else begin
					cmd.clear_item = 1'b1;
					phase_d = rsp_pkg::PH_BEGIN;
					text_d = 1'b0;
					nstage_d = 2'd0;
				end
			end
		end
	end

	assign item_type = type_d;
	assign parse_failed = fail_d;
endmodule

// ----- src/resp_stream_parser.sv -----
// Top level of the key-value protocol stream parser.
// Each accepted input transaction's result is registered in the output register.
// One byte per cycle unless the output stalls; array count pops cascade at once.
// A full output register accepts a new byte only when it is taken the same cycle.
// Reset (arst_n low): parser at message start, stack empty, flags clear.
// Depends on rsp_pkg, rsp_ctrl, rsp_datapath.
module resp_stream_parser #(
	parameter int unsigned MAX_DEPTH = rsp_pkg::DEF_MAX_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // data_byte[7:0]
	input  logic        s_tuser,  // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // byte_role[2:0] data_out[10:3] item_type[13:11]
	                              // nest_depth[18:14] length_value[50:19]
	                              // length_valid[51] element_done[52]
	                              // message_done[53] parse_failed[54], zero above
	output logic        m_tuser   // unused, zero
);
	localparam int unsigned LW = $clog2(MAX_DEPTH + 1);
	rsp_pkg::rsp_cmd_t  cmd;
	rsp_pkg::rsp_stat_t stat;
	logic        en;
	logic [2:0]  role, itype;
	logic        lv, ed, md, pf;
	logic [31:0] lval;
	logic [LW-1:0] open_lv;
	logic [LW-1:0] new_lv;
	logic [LW-1:0] open_nx;
	logic [4:0]  depth;
	logic [55:0] res_q;
	logic        vld_q;

	assign s_tready = !vld_q || m_tready;
	assign en = s_tvalid && s_tready;

	rsp_ctrl u_ctrl (
		.clk, .arst_n, .en, .req_type(s_tuser), .data_byte(s_tdata), .stat, .cmd,
		.byte_role(role), .item_type(itype), .length_valid(lv), .element_done(ed),
		.message_done(md), .parse_failed(pf)
	);

	rsp_datapath #(.MAX_DEPTH(MAX_DEPTH)) u_dp (
		.clk, .arst_n, .en, .data_byte(s_tdata), .cmd, .stat,
		.length_value(lval), .open_levels(open_lv), .next_open(new_lv)
	);

	always_comb begin
		if (cmd.restart) open_nx = '0;
		else if (cmd.push) open_nx = open_lv + LW'(1);
		else if (cmd.complete && !stat.pop_empty) open_nx = new_lv;
		else if (cmd.complete) open_nx = '0;
		else open_nx = open_lv;
		depth = 5'(open_nx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else if (s_tready) vld_q <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en) res_q <= {1'b0, pf, md, ed, lv, (lv ? lval : 32'd0), depth, itype,
			s_tdata, role};
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = res_q;
	assign m_tuser  = 1'b0;
endmodule

// ----- src/resp_stream_parser_chk.sv -----
// Port checker for resp_stream_parser, bound to the top level.
// Depends on resp_stream_parser ports and rsp_pkg.
module resp_stream_parser_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata
);
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("stall");
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser |=> m_tvalid
		&& m_tdata[2:0] == rsp_pkg::ROLE_IGNORED
		&& m_tdata[55:11] == '0) else $error("restart result");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready) else $error("ready");
	a_lv: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[51] |-> m_tdata[50:19] == '0) else $error("length");
endmodule

bind resp_stream_parser resp_stream_parser_chk u_chk (
	.clk, .arst_n, .s_tvalid, .s_tready, .s_tuser, .m_tvalid, .m_tready, .m_tdata
);
